// ===== hdl/z80ie_pkg.sv =====
// Z80 instruction encoder: shared constants, opcode values and types.
// No dependencies; used by every other file of the block.
`default_nettype none

package z80ie_pkg;

  localparam int unsigned ModeW    = 6;
  localparam int unsigned RegW     = 3;
  localparam int unsigned OperandW = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned OffsetW  = 16;
  localparam int unsigned MaxBytes = 4;
  localparam int unsigned IdxW     = $clog2(MaxBytes);
  localparam int unsigned CountW   = $clog2(MaxBytes + 1);
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CAPACITY = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN   = 1'd1;

  localparam logic [OffsetW-1:0] CAPACITY_RST = 16'hFFFF;

  // instruction forms
  localparam logic [ModeW-1:0] M_RAW_BYTE  = 6'd0;
  localparam logic [ModeW-1:0] M_RAW_WORD  = 6'd1;
  localparam logic [ModeW-1:0] M_NOP       = 6'd2;
  localparam logic [ModeW-1:0] M_HALT      = 6'd3;
  localparam logic [ModeW-1:0] M_RET       = 6'd4;
  localparam logic [ModeW-1:0] M_LD_RP_NN  = 6'd5;
  localparam logic [ModeW-1:0] M_LD_R_N    = 6'd6;
  localparam logic [ModeW-1:0] M_LD_R_R    = 6'd7;
  localparam logic [ModeW-1:0] M_LD_A_MNN  = 6'd8;
  localparam logic [ModeW-1:0] M_LD_MNN_A  = 6'd9;
  localparam logic [ModeW-1:0] M_LD_HL_MNN = 6'd10;
  localparam logic [ModeW-1:0] M_LD_MNN_HL = 6'd11;
  localparam logic [ModeW-1:0] M_LD_DE_MNN = 6'd12;
  localparam logic [ModeW-1:0] M_LD_A_MHL  = 6'd13;
  localparam logic [ModeW-1:0] M_LD_MHL_A  = 6'd14;
  localparam logic [ModeW-1:0] M_PUSH      = 6'd15;
  localparam logic [ModeW-1:0] M_POP       = 6'd16;
  localparam logic [ModeW-1:0] M_INC_R     = 6'd17;
  localparam logic [ModeW-1:0] M_DEC_R     = 6'd18;
  localparam logic [ModeW-1:0] M_INC_RP    = 6'd19;
  localparam logic [ModeW-1:0] M_DEC_RP    = 6'd20;
  localparam logic [ModeW-1:0] M_ADD_HL_RP = 6'd21;
  localparam logic [ModeW-1:0] M_SBC_HL_RP = 6'd22;
  localparam logic [ModeW-1:0] M_ADD_A_R   = 6'd23;
  localparam logic [ModeW-1:0] M_ADC_A_R   = 6'd24;
  localparam logic [ModeW-1:0] M_ADD_A_N   = 6'd25;
  localparam logic [ModeW-1:0] M_SUB_R     = 6'd26;
  localparam logic [ModeW-1:0] M_SUB_N     = 6'd27;
  localparam logic [ModeW-1:0] M_CP_R      = 6'd28;
  localparam logic [ModeW-1:0] M_CP_N      = 6'd29;
  localparam logic [ModeW-1:0] M_XOR_A     = 6'd30;
  localparam logic [ModeW-1:0] M_OR_A      = 6'd31;
  localparam logic [ModeW-1:0] M_JP_NN     = 6'd32;
  localparam logic [ModeW-1:0] M_JP_CC_NN  = 6'd33;
  localparam logic [ModeW-1:0] M_JR_E      = 6'd34;
  localparam logic [ModeW-1:0] M_JR_CC_E   = 6'd35;
  localparam logic [ModeW-1:0] M_CALL_NN   = 6'd36;
  localparam logic [ModeW-1:0] M_RST       = 6'd37;
  localparam logic [ModeW-1:0] M_EX_DE_HL  = 6'd38;
  localparam logic [ModeW-1:0] M_DJNZ      = 6'd39;
  localparam logic [ModeW-1:0] M_LDIR      = 6'd40;

  // opcode bases
  localparam logic [ByteW-1:0] OP_NOP       = 8'h00;
  localparam logic [ByteW-1:0] OP_LD_RP_NN  = 8'h01;
  localparam logic [ByteW-1:0] OP_INC_RP    = 8'h03;
  localparam logic [ByteW-1:0] OP_INC_R     = 8'h04;
  localparam logic [ByteW-1:0] OP_DEC_R     = 8'h05;
  localparam logic [ByteW-1:0] OP_LD_R_N    = 8'h06;
  localparam logic [ByteW-1:0] OP_ADD_HL_RP = 8'h09;
  localparam logic [ByteW-1:0] OP_DEC_RP    = 8'h0B;
  localparam logic [ByteW-1:0] OP_DJNZ      = 8'h10;
  localparam logic [ByteW-1:0] OP_JR        = 8'h18;
  localparam logic [ByteW-1:0] OP_JR_CC     = 8'h20;
  localparam logic [ByteW-1:0] OP_LD_MNN_HL = 8'h22;
  localparam logic [ByteW-1:0] OP_LD_HL_MNN = 8'h2A;
  localparam logic [ByteW-1:0] OP_LD_MNN_A  = 8'h32;
  localparam logic [ByteW-1:0] OP_LD_A_MNN  = 8'h3A;
  localparam logic [ByteW-1:0] OP_LD_R_R    = 8'h40;
  localparam logic [ByteW-1:0] OP_SBC_HL_RP = 8'h42;
  localparam logic [ByteW-1:0] OP_LD_DE_MNN = 8'h5B;
  localparam logic [ByteW-1:0] OP_HALT      = 8'h76;
  localparam logic [ByteW-1:0] OP_LD_MHL_A  = 8'h77;
  localparam logic [ByteW-1:0] OP_LD_A_MHL  = 8'h7E;
  localparam logic [ByteW-1:0] OP_ADD_A_R   = 8'h80;
  localparam logic [ByteW-1:0] OP_ADC_A_R   = 8'h88;
  localparam logic [ByteW-1:0] OP_SUB_R     = 8'h90;
  localparam logic [ByteW-1:0] OP_XOR_A     = 8'hAF;
  localparam logic [ByteW-1:0] OP_OR_A      = 8'hB7;
  localparam logic [ByteW-1:0] OP_LDIR_2    = 8'hB0;
  localparam logic [ByteW-1:0] OP_CP_R      = 8'hB8;
  localparam logic [ByteW-1:0] OP_POP       = 8'hC1;
  localparam logic [ByteW-1:0] OP_JP_CC     = 8'hC2;
  localparam logic [ByteW-1:0] OP_JP        = 8'hC3;
  localparam logic [ByteW-1:0] OP_PUSH      = 8'hC5;
  localparam logic [ByteW-1:0] OP_ADD_A_N   = 8'hC6;
  localparam logic [ByteW-1:0] OP_RST       = 8'hC7;
  localparam logic [ByteW-1:0] OP_RET       = 8'hC9;
  localparam logic [ByteW-1:0] OP_CALL      = 8'hCD;
  localparam logic [ByteW-1:0] OP_SUB_N     = 8'hD6;
  localparam logic [ByteW-1:0] OP_EX_DE_HL  = 8'hEB;
  localparam logic [ByteW-1:0] OP_PREFIX_ED = 8'hED;
  localparam logic [ByteW-1:0] OP_CP_N      = 8'hFE;
  localparam logic [ByteW-1:0] RST_MASK     = 8'h38;

  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic [CountW-1:0]              count;  // zero for an unused form
  } enc_t;

endpackage

`default_nettype wire

// ===== hdl/z80ie_if.sv =====
// Z80 instruction encoder: valid/ready channel interfaces for requests and bytes.
// Depends on z80ie_pkg for field widths.
`default_nettype none

interface z80ie_in_if;
  logic                               valid;
  logic                               ready;
  logic [z80ie_pkg::ModeW-1:0]        mode;
  logic [z80ie_pkg::RegW-1:0]         reg_sel;
  logic [z80ie_pkg::RegW-1:0]         reg_src;
  logic [z80ie_pkg::OperandW-1:0]     operand;

  modport source (output valid, mode, reg_sel, reg_src, operand, input ready);
  modport sink   (input valid, mode, reg_sel, reg_src, operand, output ready);
endinterface

interface z80ie_out_if;
  logic                               valid;
  logic                               ready;
  logic [z80ie_pkg::ByteW-1:0]        code_byte;
  logic [z80ie_pkg::OffsetW-1:0]      buffer_offset;
  logic                               stored;
  logic                               last_byte;

  modport source (output valid, code_byte, buffer_offset, stored, last_byte, input ready);
  modport sink   (input valid, code_byte, buffer_offset, stored, last_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/z80ie_encoder.sv =====
// Z80 instruction encoder: maps one request to its opcode bytes and byte count.
// Pure decode logic; depends on z80ie_pkg.
`default_nettype none

module z80ie_encoder (
  input  wire logic [z80ie_pkg::ModeW-1:0]    mode,
  input  wire logic [z80ie_pkg::RegW-1:0]     reg_sel,
  input  wire logic [z80ie_pkg::RegW-1:0]     reg_src,
  input  wire logic [z80ie_pkg::OperandW-1:0] operand,
  output z80ie_pkg::enc_t                     enc
);

  logic [z80ie_pkg::ByteW-1:0] lo, hi, r3, rp4, rp3, r0, rr;

  assign lo  = operand[7:0];
  assign hi  = operand[15:8];
  assign r3  = {2'b00, reg_sel, 3'b000};          // r in bits 5..3
  assign rp4 = {2'b00, reg_sel[1:0], 4'b0000};    // rp in bits 5..4
  assign rp3 = {3'b000, reg_sel[1:0], 3'b000};    // JR cc: NZ, Z, NC, C only
  assign r0  = {5'b00000, reg_sel};
  assign rr  = {2'b00, reg_sel, reg_src};

  always_comb begin
    enc.bytes = '0;
    enc.count = '0;
    unique case (mode)
      z80ie_pkg::M_RAW_BYTE:  begin enc.bytes[0] = lo; enc.count = 3'd1; end
      z80ie_pkg::M_RAW_WORD:  begin
        enc.bytes[0] = lo; enc.bytes[1] = hi; enc.count = 3'd2;
      end
      z80ie_pkg::M_NOP:       begin enc.bytes[0] = z80ie_pkg::OP_NOP;  enc.count = 3'd1; end
      z80ie_pkg::M_HALT:      begin enc.bytes[0] = z80ie_pkg::OP_HALT; enc.count = 3'd1; end
      z80ie_pkg::M_RET:       begin enc.bytes[0] = z80ie_pkg::OP_RET;  enc.count = 3'd1; end
      z80ie_pkg::M_LD_RP_NN:  begin
        enc.bytes[0] = z80ie_pkg::OP_LD_RP_NN | rp4;
        enc.bytes[1] = lo; enc.bytes[2] = hi; enc.count = 3'd3;
      end
      z80ie_pkg::M_LD_R_N:    begin
        enc.bytes[0] = z80ie_pkg::OP_LD_R_N | r3; enc.bytes[1] = lo; enc.count = 3'd2;
      end
      // both registers 6 lands on the HALT opcode, as the processor defines it
      z80ie_pkg::M_LD_R_R:    begin enc.bytes[0] = z80ie_pkg::OP_LD_R_R | rr; enc.count = 3'd1; end
      z80ie_pkg::M_LD_A_MNN:  begin
        enc.bytes[0] = z80ie_pkg::OP_LD_A_MNN; enc.bytes[1] = lo; enc.bytes[2] = hi;
        enc.count = 3'd3;
      end
      z80ie_pkg::M_LD_MNN_A:  begin
        enc.bytes[0] = z80ie_pkg::OP_LD_MNN_A; enc.bytes[1] = lo; enc.bytes[2] = hi;
        enc.count = 3'd3;
      end
      z80ie_pkg::M_LD_HL_MNN: begin
        enc.bytes[0] = z80ie_pkg::OP_LD_HL_MNN; enc.bytes[1] = lo; enc.bytes[2] = hi;
        enc.count = 3'd3;
      end
      z80ie_pkg::M_LD_MNN_HL: begin
        enc.bytes[0] = z80ie_pkg::OP_LD_MNN_HL; enc.bytes[1] = lo; enc.bytes[2] = hi;
        enc.count = 3'd3;
      end
      z80ie_pkg::M_LD_DE_MNN: begin
        enc.bytes[0] = z80ie_pkg::OP_PREFIX_ED; enc.bytes[1] = z80ie_pkg::OP_LD_DE_MNN;
        enc.bytes[2] = lo; enc.bytes[3] = hi; enc.count = 3'd4;
      end
      z80ie_pkg::M_LD_A_MHL:  begin enc.bytes[0] = z80ie_pkg::OP_LD_A_MHL; enc.count = 3'd1; end
      z80ie_pkg::M_LD_MHL_A:  begin enc.bytes[0] = z80ie_pkg::OP_LD_MHL_A; enc.count = 3'd1; end
      z80ie_pkg::M_PUSH:      begin enc.bytes[0] = z80ie_pkg::OP_PUSH | rp4; enc.count = 3'd1; end
      z80ie_pkg::M_POP:       begin enc.bytes[0] = z80ie_pkg::OP_POP | rp4;  enc.count = 3'd1; end
      z80ie_pkg::M_INC_R:     begin enc.bytes[0] = z80ie_pkg::OP_INC_R | r3; enc.count = 3'd1; end
      z80ie_pkg::M_DEC_R:     begin enc.bytes[0] = z80ie_pkg::OP_DEC_R | r3; enc.count = 3'd1; end
      z80ie_pkg::M_INC_RP:    begin enc.bytes[0] = z80ie_pkg::OP_INC_RP | rp4; enc.count = 3'd1; end
      z80ie_pkg::M_DEC_RP:    begin enc.bytes[0] = z80ie_pkg::OP_DEC_RP | rp4; enc.count = 3'd1; end
      z80ie_pkg::M_ADD_HL_RP: begin
        enc.bytes[0] = z80ie_pkg::OP_ADD_HL_RP | rp4; enc.count = 3'd1;
      end
      z80ie_pkg::M_SBC_HL_RP: begin
        enc.bytes[0] = z80ie_pkg::OP_PREFIX_ED;
        enc.bytes[1] = z80ie_pkg::OP_SBC_HL_RP | rp4; enc.count = 3'd2;
      end
      z80ie_pkg::M_ADD_A_R:   begin enc.bytes[0] = z80ie_pkg::OP_ADD_A_R | r0; enc.count = 3'd1; end
      z80ie_pkg::M_ADC_A_R:   begin enc.bytes[0] = z80ie_pkg::OP_ADC_A_R | r0; enc.count = 3'd1; end
      z80ie_pkg::M_ADD_A_N:   begin
        enc.bytes[0] = z80ie_pkg::OP_ADD_A_N; enc.bytes[1] = lo; enc.count = 3'd2;
      end
      z80ie_pkg::M_SUB_R:     begin enc.bytes[0] = z80ie_pkg::OP_SUB_R | r0; enc.count = 3'd1; end
      z80ie_pkg::M_SUB_N:     begin
        enc.bytes[0] = z80ie_pkg::OP_SUB_N; enc.bytes[1] = lo; enc.count = 3'd2;
      end
      z80ie_pkg::M_CP_R:      begin enc.bytes[0] = z80ie_pkg::OP_CP_R | r0; enc.count = 3'd1; end
      z80ie_pkg::M_CP_N:      begin
        enc.bytes[0] = z80ie_pkg::OP_CP_N; enc.bytes[1] = lo; enc.count = 3'd2;
      end
      z80ie_pkg::M_XOR_A:     begin enc.bytes[0] = z80ie_pkg::OP_XOR_A; enc.count = 3'd1; end
      z80ie_pkg::M_OR_A:      begin enc.bytes[0] = z80ie_pkg::OP_OR_A;  enc.count = 3'd1; end
      z80ie_pkg::M_JP_NN:     begin
        enc.bytes[0] = z80ie_pkg::OP_JP; enc.bytes[1] = lo; enc.bytes[2] = hi;
        enc.count = 3'd3;
      end
      z80ie_pkg::M_JP_CC_NN:  begin
        enc.bytes[0] = z80ie_pkg::OP_JP_CC | r3; enc.bytes[1] = lo; enc.bytes[2] = hi;
        enc.count = 3'd3;
      end
      z80ie_pkg::M_JR_E:      begin
        enc.bytes[0] = z80ie_pkg::OP_JR; enc.bytes[1] = lo; enc.count = 3'd2;
      end
      z80ie_pkg::M_JR_CC_E:   begin
        enc.bytes[0] = z80ie_pkg::OP_JR_CC | rp3; enc.bytes[1] = lo; enc.count = 3'd2;
      end
      z80ie_pkg::M_CALL_NN:   begin
        enc.bytes[0] = z80ie_pkg::OP_CALL; enc.bytes[1] = lo; enc.bytes[2] = hi;
        enc.count = 3'd3;
      end
      z80ie_pkg::M_RST:       begin
        enc.bytes[0] = z80ie_pkg::OP_RST | (lo & z80ie_pkg::RST_MASK); enc.count = 3'd1;
      end
      z80ie_pkg::M_EX_DE_HL:  begin enc.bytes[0] = z80ie_pkg::OP_EX_DE_HL; enc.count = 3'd1; end
      z80ie_pkg::M_DJNZ:      begin
        enc.bytes[0] = z80ie_pkg::OP_DJNZ; enc.bytes[1] = lo; enc.count = 3'd2;
      end
      z80ie_pkg::M_LDIR:      begin
        enc.bytes[0] = z80ie_pkg::OP_PREFIX_ED; enc.bytes[1] = z80ie_pkg::OP_LDIR_2;
        enc.count = 3'd2;
      end
      default:                begin enc.bytes = '0; enc.count = '0; end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/z80ie_emitter.sv =====
// Z80 instruction encoder: request register, byte sequencing, size counter
// and result register. Depends on z80ie_pkg, z80ie_if and z80ie_encoder.
`default_nettype none

module z80ie_emitter (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [z80ie_pkg::OffsetW-1:0]   capacity,
  z80ie_in_if.sink                             req,
  z80ie_out_if.source                          rsp
);

  logic                              hold_vld_r;
  logic [z80ie_pkg::ModeW-1:0]       mode_r;
  logic [z80ie_pkg::RegW-1:0]        reg_sel_r;
  logic [z80ie_pkg::RegW-1:0]        reg_src_r;
  logic [z80ie_pkg::OperandW-1:0]    operand_r;
  logic [z80ie_pkg::IdxW-1:0]        idx_r, idx_nxt;
  logic [z80ie_pkg::OffsetW-1:0]     used_r, used_nxt;

  logic                              out_vld_r, out_vld_nxt;
  logic [z80ie_pkg::ByteW-1:0]       byte_r;
  logic [z80ie_pkg::OffsetW-1:0]     offset_r;
  logic                              stored_r;
  logic                              last_r;

  z80ie_pkg::enc_t                   enc;
  logic                              out_free, move, is_last, fits, release_hold, take;

  z80ie_encoder u_enc (
    .mode    (mode_r),
    .reg_sel (reg_sel_r),
    .reg_src (reg_src_r),
    .operand (operand_r),
    .enc     (enc)
  );

  assign out_free     = !out_vld_r || rsp.ready;
  assign is_last      = ({1'b0, idx_r} == (enc.count - 3'd1));
  assign move         = hold_vld_r && (enc.count != '0) && out_free;
  assign fits         = used_r < capacity;
  // an unused form frees the request register without a beat
  assign release_hold = hold_vld_r && ((enc.count == '0) || (move && is_last));
  assign req.ready    = !hold_vld_r || release_hold;
  assign take         = req.valid && req.ready;

  always_comb begin
    idx_nxt     = idx_r;
    used_nxt    = used_r;
    out_vld_nxt = out_vld_r;
    if (out_free) begin
      out_vld_nxt = move;
    end
    if (move) begin
      idx_nxt = idx_r + 2'd1;
      if (fits) begin
        used_nxt = used_r + 16'd1;
      end
    end
    if (take) begin
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      idx_r      <= '0;
      used_r     <= '0;
    end else begin
      hold_vld_r <= take || (hold_vld_r && !release_hold);
      out_vld_r  <= out_vld_nxt;
      idx_r      <= idx_nxt;
      used_r     <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mode_r    <= req.mode;
      reg_sel_r <= req.reg_sel;
      reg_src_r <= req.reg_src;
      operand_r <= req.operand;
    end
    if (move) begin
      byte_r   <= enc.bytes[idx_r];
      offset_r <= used_r;
      stored_r <= fits;
      last_r   <= is_last;
    end
  end

  assign rsp.valid         = out_vld_r;
  assign rsp.code_byte     = byte_r;
  assign rsp.buffer_offset = offset_r;
  assign rsp.stored        = stored_r;
  assign rsp.last_byte     = last_r;

endmodule

`default_nettype wire

// ===== hdl/z80_instruction_encoder.sv =====
// Z80 instruction encoder top level: configuration registers and the byte emitter.
// Depends on z80ie_pkg, z80ie_if and z80ie_emitter.
//
// Each request on in_ch (one of 41 instruction forms) gives 1 to 4 machine-code
// beats on out_ch, one byte per cycle while out_ch does not stall, words low byte
// first, each with its buffer offset, a stored flag and a last-byte flag. An
// instruction holds the request register until its last byte moves out to the
// one-byte result register; a new request is taken in the cycle its predecessor's
// last byte moves out. Unused forms give no beat. Bytes at or past the capacity
// register are flagged not stored and do not advance the size counter. Writes to
// the origin register (CFG_ORIGIN) are accepted but have no effect on offsets,
// which are buffer-relative.
`default_nettype none

module z80_instruction_encoder (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [z80ie_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [z80ie_pkg::CfgDataW-1:0]   cfg_wdata,
  z80ie_in_if.sink                              in_ch,
  z80ie_out_if.source                           out_ch
);

  logic [z80ie_pkg::OffsetW-1:0] capacity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= z80ie_pkg::CAPACITY_RST;
    end else if (cfg_we && (cfg_index == z80ie_pkg::CFG_CAPACITY)) begin
      capacity_r <= cfg_wdata;
    end
  end

  z80ie_emitter u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .capacity (capacity_r),
    .req      (in_ch),
    .rsp      (out_ch)
  );

endmodule

`default_nettype wire
